// ===== rtl/bafcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bafcs_pkg
// Shared types and constants for the bit array flip/count/search block.
// ----------------------------------------------------------------------------
package bafcs_pkg;

    localparam int SIZE     = 1024;
    localparam int POS_W    = 10;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int WORDS    = SIZE / WORD_W;
    localparam int WIDX_W   = POS_W - BIT_W;
    localparam int VALUE_W  = 11;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam logic [3:0] MODE_SET      = 4'd0;
    localparam logic [3:0] MODE_FLIP     = 4'd1;
    localparam logic [3:0] MODE_COUNT    = 4'd2;
    localparam logic [3:0] MODE_READ     = 4'd3;
    localparam logic [3:0] MODE_NEAR0_R  = 4'd4;
    localparam logic [3:0] MODE_NEAR0_L  = 4'd5;
    localparam logic [3:0] MODE_NEAR1_R  = 4'd6;
    localparam logic [3:0] MODE_NEAR1_L  = 4'd7;
    localparam logic [3:0] MODE_ADD      = 4'd8;
    localparam logic [3:0] MODE_SUB      = 4'd9;

    typedef struct packed {
        logic [BIT_W:0]   ones;
        logic             any;
        logic [BIT_W-1:0] low;
        logic [BIT_W-1:0] high;
    } unit_res_t;

endpackage

// ===== rtl/bafcs_if.sv =====
// ----------------------------------------------------------------------------
// bafcs_req_if / bafcs_rsp_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface bafcs_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] mode;
    logic [9:0] range_low;
    logic [9:0] range_high;
    logic       bit_value;

    modport source (output valid, mode, range_low, range_high, bit_value, input ready);
    modport sink   (input valid, mode, range_low, range_high, bit_value, output ready);
endinterface

interface bafcs_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] value;
    logic        found;
    logic        error;

    modport source (output valid, value, found, error, input ready);
    modport sink   (input valid, value, found, error, output ready);
endinterface

// ===== rtl/bafcs_word_unit.sv =====
// ----------------------------------------------------------------------------
// bafcs_word_unit
// Shared word unit: ones count under a mask and lowest/highest match.
// ----------------------------------------------------------------------------
module bafcs_word_unit
(
    input  bafcs_pkg::word_t     word,
    input  bafcs_pkg::word_t     mask,
    input  logic                 target,
    output bafcs_pkg::unit_res_t res
);
    import bafcs_pkg::*;

    word_t cand;

    always_comb
    begin
        cand     = (target ? word : ~word) & mask;
        res.ones = BIT_W'(0) + ($bits(res.ones))'($countones(word & mask));
        res.any  = |cand;
        res.low  = '0;
        res.high = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                res.low = BIT_W'(i);
            end
        end
        for (int i = 0; i < WORD_W; i++)
        begin
            if (cand[i])
            begin
                res.high = BIT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/bit_array_flip_count_search.sv =====
// ----------------------------------------------------------------------------
// bit_array_flip_count_search
// 1024-bit array with set, range flip, range count, read, nearest search,
// and add/subtract of a power of two.
//
// Usage:
//   req carries one operation item (mode, range_low, range_high, bit_value);
//   rsp returns one result item (value, found, error) for each.
//   The array is held as 32 words of 32 bits; one shared word unit masks,
//   counts and searches one word per cycle under a small sequencer.
//   Set, read and unused modes finish on accept; the result shows in the next cycle.
//   Flip and count walk every word spanned by the range, one after another.
//   Searches walk words from the start word until a hit or the array end.
//   Add/subtract: search, then flip from range_low up to the hit.
//   One item is in work at a time; req.ready is high only when idle, so the
//   next item can be accepted in the cycle after the result is taken.
//   Reset clears the whole array to zero at once; no sweep is needed.
//   A result holds on rsp until taken; the block stays busy meanwhile.
// ----------------------------------------------------------------------------
module bit_array_flip_count_search
(
    input  logic        clk,
    input  logic        rst_n,
    bafcs_req_if.sink   req,
    bafcs_rsp_if.source rsp
);
    import bafcs_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;
    typedef enum logic [1:0] {K_FLIP, K_COUNT, K_FIND_LO, K_FIND_HI} kind_t;

    state_t              state_reg;
    kind_t               kind_reg;
    logic                arith_reg;
    logic                target_reg;
    pos_t                lo_reg;
    pos_t                hi_reg;
    logic [WIDX_W-1:0]   w_reg;
    logic [WIDX_W-1:0]   end_reg;
    value_t              acc_reg;
    value_t              value_reg;
    logic                found_reg;
    logic                error_reg;
    word_t               mem_reg [WORDS];

    word_t               cur_word;
    word_t               lo_mask;
    word_t               hi_mask;
    word_t               mask;
    unit_res_t           ures;
    logic                last_w;
    pos_t                hit_lo;
    pos_t                hit_hi;

    assign cur_word = mem_reg[w_reg];
    assign lo_mask  = (w_reg == lo_reg[POS_W-1:BIT_W]) ? ('1 << lo_reg[BIT_W-1:0]) : '1;
    assign hi_mask  = (w_reg == hi_reg[POS_W-1:BIT_W])
                      ? ('1 >> (BIT_W'(WORD_W - 1) - hi_reg[BIT_W-1:0])) : '1;
    assign mask     = lo_mask & hi_mask;
    assign last_w   = (w_reg == end_reg);
    assign hit_lo   = {w_reg, ures.low};
    assign hit_hi   = {w_reg, ures.high};

    bafcs_word_unit u_unit
    (
        .word   (cur_word),
        .mask   (mask),
        .target (target_reg),
        .res    (ures)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_DONE);
    assign rsp.value = value_reg;
    assign rsp.found = found_reg;
    assign rsp.error = error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < WORDS; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        value_reg  <= '0;
                        found_reg  <= 1'b0;
                        error_reg  <= 1'b0;
                        acc_reg    <= '0;
                        arith_reg  <= 1'b0;
                        target_reg <= 1'b0;
                        lo_reg     <= req.range_low;
                        hi_reg     <= req.range_high;
                        w_reg      <= req.range_low[POS_W-1:BIT_W];
                        end_reg    <= req.range_high[POS_W-1:BIT_W];
                        state_reg  <= S_DONE;
                        case (req.mode)
                            MODE_SET:
                            begin
                                mem_reg[req.range_low[POS_W-1:BIT_W]]
                                       [req.range_low[BIT_W-1:0]] <= req.bit_value;
                            end
                            MODE_READ:
                            begin
                                value_reg <= VALUE_W'(mem_reg[req.range_low[POS_W-1:BIT_W]]
                                                             [req.range_low[BIT_W-1:0]]);
                            end
                            MODE_FLIP, MODE_COUNT:
                            begin
                                kind_reg <= (req.mode == MODE_FLIP) ? K_FLIP : K_COUNT;
                                if (req.range_low <= req.range_high)
                                begin
                                    state_reg <= S_WALK;
                                end
                            end
                            MODE_NEAR0_R, MODE_NEAR1_R, MODE_ADD, MODE_SUB:
                            begin
                                kind_reg   <= K_FIND_LO;
                                target_reg <= (req.mode == MODE_NEAR1_R) || (req.mode == MODE_SUB);
                                arith_reg  <= (req.mode == MODE_ADD) || (req.mode == MODE_SUB);
                                hi_reg     <= POS_W'(SIZE - 1);
                                end_reg    <= WIDX_W'(WORDS - 1);
                                state_reg  <= S_WALK;
                            end
                            MODE_NEAR0_L, MODE_NEAR1_L:
                            begin
                                kind_reg   <= K_FIND_HI;
                                target_reg <= (req.mode == MODE_NEAR1_L);
                                lo_reg     <= '0;
                                hi_reg     <= req.range_low;
                                end_reg    <= '0;
                                state_reg  <= S_WALK;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    case (kind_reg)
                        K_FLIP:
                        begin
                            mem_reg[w_reg] <= cur_word ^ mask;
                            w_reg          <= w_reg + 1'b1;
                            if (last_w)
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        K_COUNT:
                        begin
                            acc_reg <= acc_reg + VALUE_W'(ures.ones);
                            w_reg   <= w_reg + 1'b1;
                            if (last_w)
                            begin
                                value_reg <= acc_reg + VALUE_W'(ures.ones);
                                state_reg <= S_DONE;
                            end
                        end
                        K_FIND_LO:
                        begin
                            w_reg <= w_reg + 1'b1;
                            if (ures.any)
                            begin
                                if (arith_reg)
                                begin
                                    kind_reg <= K_FLIP;
                                    hi_reg   <= hit_lo;
                                    w_reg    <= lo_reg[POS_W-1:BIT_W];
                                    end_reg  <= w_reg;
                                end
                                else
                                begin
                                    value_reg <= VALUE_W'(hit_lo);
                                    found_reg <= 1'b1;
                                    state_reg <= S_DONE;
                                end
                            end
                            else if (last_w)
                            begin
                                error_reg <= arith_reg;
                                state_reg <= S_DONE;
                            end
                        end
                        K_FIND_HI:
                        begin
                            w_reg <= w_reg - 1'b1;
                            if (ures.any)
                            begin
                                value_reg <= VALUE_W'(hit_hi);
                                found_reg <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            else if (last_w)
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.found && rsp.error))
        else $error("found and error both set");

    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.value < VALUE_W'(SIZE)))
        else $error("found position beyond array");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("accepted two items back to back");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.value <= VALUE_W'(SIZE)))
        else $error("result value out of range");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed operation items into the bit array block and
// checks every result against a flat bit-array model of the same operations.
// ----------------------------------------------------------------------------
module tb_top;
    import bafcs_pkg::*;

    localparam logic [3:0] MODE_RSVD_A = 4'd10;
    localparam logic [3:0] MODE_RSVD_F = 4'd15;

    typedef struct packed {
        logic [3:0] mode;
        logic [9:0] lo;
        logic [9:0] hi;
        logic       b;
    } op_t;

    typedef struct packed {
        logic [10:0] value;
        logic        found;
        logic        error;
    } res_t;

    logic clk;
    logic rst_n;

    bafcs_req_if req();
    bafcs_rsp_if rsp();

    bit_array_flip_count_search uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    op_t  pending_ops[$];
    res_t expected_res[$];
    logic [SIZE-1:0] bits = '0;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_start;
    logic hold_active;
    int   quiet_cycles;
    int   errors = 0;

    function automatic res_t apply_op(op_t op);
        res_t r;
        int hi;
        int lo;
        int p;
        logic want;
        r = '0;
        lo = int'(op.lo);
        hi = (op.hi > SIZE - 1) ? SIZE - 1 : int'(op.hi);
        p = -1;
        case (op.mode)
            MODE_SET:
                if (lo < SIZE)
                    bits[lo] = op.b;
            MODE_FLIP:
                for (int i = lo; i <= hi; i++)
                    bits[i] = ~bits[i];
            MODE_COUNT:
                for (int i = lo; i <= hi; i++)
                    r.value += 11'(bits[i]);
            MODE_READ:
                if (lo < SIZE)
                    r.value = 11'(bits[lo]);
            MODE_NEAR0_R, MODE_NEAR1_R:
            begin
                want = (op.mode == MODE_NEAR1_R);
                for (int i = lo; i < SIZE && p < 0; i++)
                    if (bits[i] == want)
                        p = i;
            end
            MODE_NEAR0_L, MODE_NEAR1_L:
            begin
                want = (op.mode == MODE_NEAR1_L);
                for (int i = (lo > SIZE - 1 ? SIZE - 1 : lo); i >= 0 && p < 0; i--)
                    if (bits[i] == want)
                        p = i;
            end
            MODE_ADD, MODE_SUB:
            begin
                want = (op.mode == MODE_SUB);
                for (int i = lo; i < SIZE && p < 0; i++)
                    if (bits[i] == want)
                        p = i;
                if (p < 0)
                    r.error = 1'b1;
                else
                    for (int i = lo; i <= p; i++)
                        bits[i] = ~bits[i];
                p = -1;
            end
            default: ;
        endcase
        if (p >= 0)
        begin
            r.value = 11'(p);
            r.found = 1'b1;
        end
        return r;
    endfunction

    function automatic op_t rand_op();
        op_t op;
        int k;
        op.mode = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(MODE_RSVD_A, MODE_RSVD_F))
                                               : 4'($urandom_range(MODE_SET, MODE_SUB));
        k = $urandom_range(0, 9);
        op.lo = (k == 0) ? 10'd0 : (k == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 3) == 0)
            op.hi = 10'($urandom_range(0, 1023));
        else
            op.hi = op.lo + 10'($urandom_range(0, 80));
        op.b = 1'($urandom_range(0, 1));
        if (op.mode == MODE_ADD || op.mode == MODE_SUB)
            op.lo = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 40));
        return op;
    endfunction

    function automatic op_t mk(logic [3:0] m, int lo, int hi, bit b);
        op_t op;
        op.mode = m;
        op.lo = 10'(lo);
        op.hi = 10'(hi);
        op.b = b;
        return op;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= '0;
            req.range_low <= '0;
            req.range_high <= '0;
            req.bit_value <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_res.push_back(apply_op({req.mode, req.range_low,
                                                  req.range_high, req.bit_value}));
            if (!req.valid || req.ready)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    op_t op;
                    op = pending_ops.pop_front();
                    req.valid <= 1'b1;
                    req.mode <= op.mode;
                    req.range_low <= op.lo;
                    req.range_high <= op.hi;
                    req.bit_value <= op.b;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // long receiver hold
    initial
    begin
        hold_active = 1'b0;
        wait (hold_start);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (300) @(posedge clk);
        hold_active <= 1'b0;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d found=%0b error=%0b", $time,
                             rsp.value, rsp.found, rsp.error);
                    errors++;
                end
                else
                begin
                    res_t e;
                    e = expected_res.pop_front();
                    if (e != {rsp.value, rsp.found, rsp.error})
                    begin
                        $display("%0t: mismatch expected value=%0d found=%0b error=%0b,",
                                 $time, e.value, e.found, e.error);
                        $display("    actual value=%0d found=%0b error=%0b",
                                 rsp.value, rsp.found, rsp.error);
                        errors++;
                    end
                end
            end
            if (hold_active)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("FAIL bit_array_flip_count_search");
                $finish;
            end
        end
    end

    task automatic run_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++)
            pending_ops.push_back(rand_op());
        wait (pending_ops.size() == 0);
    endtask

    initial
    begin
        hold_start = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        pending_ops.push_back(mk(MODE_NEAR1_R, 0, 0, 0));
        pending_ops.push_back(mk(MODE_NEAR1_L, 1023, 0, 0));
        pending_ops.push_back(mk(MODE_SUB, 0, 0, 0));
        pending_ops.push_back(mk(MODE_SET, 0, 0, 1));
        pending_ops.push_back(mk(MODE_SET, 1023, 0, 1));
        pending_ops.push_back(mk(MODE_READ, 1023, 0, 0));
        pending_ops.push_back(mk(MODE_COUNT, 0, 1023, 0));
        pending_ops.push_back(mk(MODE_FLIP, 0, 1023, 0));
        pending_ops.push_back(mk(MODE_COUNT, 0, 1023, 0));
        pending_ops.push_back(mk(MODE_ADD, 0, 0, 0));
        pending_ops.push_back(mk(MODE_NEAR0_R, 0, 0, 0));
        pending_ops.push_back(mk(MODE_NEAR0_L, 1023, 0, 0));
        pending_ops.push_back(mk(MODE_ADD, 1, 0, 0));
        pending_ops.push_back(mk(MODE_SUB, 1023, 0, 0));
        pending_ops.push_back(mk(MODE_ADD, 1023, 0, 0));
        pending_ops.push_back(mk(MODE_FLIP, 700, 300, 0));
        pending_ops.push_back(mk(MODE_COUNT, 700, 300, 0));
        pending_ops.push_back(mk(MODE_FLIP, 31, 32, 0));
        pending_ops.push_back(mk(MODE_NEAR1_R, 5, 0, 0));
        pending_ops.push_back(mk(MODE_NEAR1_L, 500, 0, 0));
        pending_ops.push_back(mk(MODE_READ, 0, 0, 0));
        pending_ops.push_back(mk(MODE_RSVD_F, 1023, 1023, 1));
        pending_ops.push_back(mk(MODE_RSVD_A, 0, 0, 0));
        wait (pending_ops.size() == 0);

        hold_start = 1'b1;
        run_phase(40, 0, 0);
        run_phase(250, 0, 0);
        run_phase(250, 67, 0);
        run_phase(250, 0, 67);
        run_phase(250, 23, 23);

        wait (!req.valid && expected_res.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS bit_array_flip_count_search");
        else
            $display("FAIL bit_array_flip_count_search");
        $finish;
    end
endmodule
